### hw/rtl/hslc_pkg.sv
// ----------------------------------------------------------------------------
// hslc_pkg
// Shared widths, defaults, codes and build-time functions of the hair-cell
// sigmoid / low-pass cascade.
// ----------------------------------------------------------------------------
package hslc_pkg;

  // default sizes
  localparam int CHANNELS_DEF  = 64;
  localparam int STAGES_DEF    = 4;
  localparam int SIG_DEPTH_DEF = 1024;

  // field widths
  localparam int CH_W       = 6;
  localparam int SAMPLE_W   = 16;
  localparam int DATA_W     = 32;
  localparam int GAIN_W     = 16;
  localparam int COEF_A_W   = 16;
  localparam int COEF_B_W   = 24;
  localparam int ROM_W      = 18;
  localparam int CFG_ADDR_W = 4;
  localparam int CFG_DATA_W = 32;

  // datapath widths
  localparam int DRV_PROD_W = ROM_W + GAIN_W + 1;        // gain * entry
  localparam int FB_PROD_W  = DATA_W + COEF_B_W + 1;     // coef_b * y_prev
  localparam int FB_W       = FB_PROD_W - 16;            // feedback, Q16
  localparam int INNER_W    = FB_W + 1;                  // x + x_prev + fb
  localparam int A_PROD_W   = INNER_W + COEF_A_W + 1;    // coef_a * inner
  localparam int Y_W        = A_PROD_W - 16;

  // register reset values
  localparam logic [GAIN_W-1:0]   GAIN_RST   = 16'd25600;
  localparam logic [COEF_A_W-1:0] COEF_A_RST = 16'd5650;
  localparam logic [COEF_B_W-1:0] COEF_B_RST = 24'd629146;

  // sigmoid constants
  localparam int SIG_X0  = 27;
  localparam int SIG_X1  = 27;
  localparam int SIG_SX0 = 85;
  localparam int SIG_SX1 = 11;
  localparam logic signed [DATA_W-1:0] GA0_Q16 = 32'sd3568;

  localparam logic [63:0] ONE_Q32 = 64'h0000_0001_0000_0000;

  // register indexes
  typedef enum logic [1:0] {
    REG_GAIN   = 2'd0,
    REG_COEF_A = 2'd1,
    REG_COEF_B = 2'd2
  } reg_idx_t;

  // sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DRV,
    ST_SUM,
    ST_MULA,
    ST_FIN
  } seq_state_t;

  // write strobes toward the state memories
  typedef struct packed {
    logic drv_we;
    logic stg_we;
  } mem_ctl_t;

  // restoring divide, used only while building the sigmoid table
  function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
    logic [64:0] rem;
    logic [63:0] quo;
    rem = '0;
    quo = '0;
    for (int i = 63; i >= 0; i--) begin
      rem = {rem[63:0], num[i]};
      if (rem >= {1'b0, den}) begin
        rem    = rem - {1'b0, den};
        quo[i] = 1'b1;
      end
    end
    return quo;
  endfunction

  // e^(-1/s) in Q32 from the first thirteen series terms
  function automatic logic [63:0] exp_neg_unit(input logic [31:0] s);
    logic [63:0] sum;
    logic [63:0] term;
    sum  = ONE_Q32;
    term = ONE_Q32;
    for (int k = 1; k <= 12; k++) begin
      term = udiv64(term, 64'(s) * 64'(k));
      if (k % 2 == 1) begin
        sum = sum - term;
      end else begin
        sum = sum + term;
      end
    end
    return sum;
  endfunction

  // Q32 product, rounded half up
  function automatic logic [63:0] mul_q32(input logic [63:0] a, input logic [63:0] b);
    logic [63:0] p;
    p = a * b;
    p = p + 64'h0000_0000_8000_0000;
    return p >> 32;
  endfunction

  // base^n by square and multiply
  function automatic logic [63:0] exp_neg_pow(input logic [63:0] base, input logic [31:0] n);
    logic [63:0] r;
    logic [63:0] b;
    r = ONE_Q32;
    b = base;
    for (int i = 0; i < 32; i++) begin
      if (n[i]) begin
        r = mul_q32(r, b);
      end
      b = mul_q32(b, b);
    end
    return r;
  endfunction

  // logistic 1/(1+e^-(n/s)) in Q30
  function automatic logic [63:0] logistic_q30(input int n, input logic [63:0] unit);
    logic [31:0] mag;
    logic [63:0] e;
    logic [63:0] num;
    logic [63:0] den;
    mag = (n >= 0) ? 32'(n) : 32'(-n);
    e   = exp_neg_pow(unit, mag);
    num = (n >= 0) ? ONE_Q32 : e;
    den = ONE_Q32 + e;
    return udiv64((num << 30) + (den >> 1), den);
  endfunction

  // five times the two-term sigmoid, Q30
  function automatic logic [63:0] sigmoid_scaled(input int x, input logic [63:0] u0,
                                                 input logic [63:0] u1);
    return 64'd3 * logistic_q30(x - SIG_X0, u0) + 64'd2 * logistic_q30(x - SIG_X1, u1);
  endfunction

  // table entry: S(x)-S(0) in signed Q16, rounded half up
  function automatic logic signed [ROM_W-1:0] rom_entry(input int x, input logic [63:0] u0,
                                                        input logic [63:0] u1,
                                                        input logic [63:0] rest);
    logic [63:0] biased;
    logic [63:0] q;
    biased = sigmoid_scaled(x, u0, u1) - rest + 64'd10737418240 + 64'd40960;
    q      = udiv64(biased, 64'd81920);
    return ROM_W'(q - 64'd131072);
  endfunction

endpackage

### hw/rtl/hslc_sig_rom.sv
// ----------------------------------------------------------------------------
// hslc_sig_rom
// Sigmoid lookup ROM, contents built at elaboration, registered read.
// ----------------------------------------------------------------------------
module hslc_sig_rom #(
  parameter int SIGMOID_TABLE_DEPTH = hslc_pkg::SIG_DEPTH_DEF,
  localparam int AW = $clog2(SIGMOID_TABLE_DEPTH)
) (
  input  logic                               clk,
  input  logic [AW-1:0]                      rom_addr,
  output logic signed [hslc_pkg::ROM_W-1:0]  rom_data
);

  typedef logic signed [hslc_pkg::ROM_W-1:0] rom_arr_t [SIGMOID_TABLE_DEPTH];

  // entry i stands for input x = i - depth/2
  function automatic rom_arr_t build_rom();
    rom_arr_t    tbl;
    logic [63:0] u0;
    logic [63:0] u1;
    logic [63:0] rest;
    u0   = hslc_pkg::exp_neg_unit(32'(hslc_pkg::SIG_SX0));
    u1   = hslc_pkg::exp_neg_unit(32'(hslc_pkg::SIG_SX1));
    rest = hslc_pkg::sigmoid_scaled(0, u0, u1);
    for (int i = 0; i < SIGMOID_TABLE_DEPTH; i++) begin
      tbl[i] = hslc_pkg::rom_entry(i - SIGMOID_TABLE_DEPTH / 2, u0, u1, rest);
    end
    return tbl;
  endfunction

  localparam rom_arr_t ROM_TBL = build_rom();

  logic signed [hslc_pkg::ROM_W-1:0] rom_data_r;

  // registered read
  always_ff @(posedge clk) begin
    rom_data_r <= ROM_TBL[rom_addr];
  end

  assign rom_data = rom_data_r;

endmodule

### hw/rtl/hslc_state_mem.sv
// ----------------------------------------------------------------------------
// hslc_state_mem
// Per-channel state: previous drive and previous stage outputs, with the
// clearing pass that loads reset values after reset.
// ----------------------------------------------------------------------------
module hslc_state_mem #(
  parameter int CHANNELS = hslc_pkg::CHANNELS_DEF,
  parameter int STAGES   = hslc_pkg::STAGES_DEF,
  localparam int CW      = (CHANNELS > 1) ? $clog2(CHANNELS) : 1,
  localparam int KW      = (STAGES > 1) ? $clog2(STAGES) : 1,
  localparam int SAW     = CW + KW
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  hslc_pkg::mem_ctl_t                  mem_ctl,
  input  logic [CW-1:0]                       drv_raddr,
  input  logic [CW-1:0]                       drv_waddr,
  input  logic signed [hslc_pkg::DATA_W-1:0]  drv_wdata,
  output logic signed [hslc_pkg::DATA_W-1:0]  drv_rdata,
  input  logic [SAW-1:0]                      stg_raddr,
  input  logic [SAW-1:0]                      stg_waddr,
  input  logic signed [hslc_pkg::DATA_W-1:0]  stg_wdata,
  output logic signed [hslc_pkg::DATA_W-1:0]  stg_rdata,
  output logic                                clear_busy
);

  localparam int SDEPTH = CHANNELS << KW;

  logic signed [hslc_pkg::DATA_W-1:0] drv_mem [CHANNELS];
  logic signed [hslc_pkg::DATA_W-1:0] stg_mem [SDEPTH];

  logic signed [hslc_pkg::DATA_W-1:0] drv_q_r;
  logic signed [hslc_pkg::DATA_W-1:0] stg_q_r;
  logic                               busy_r;
  logic [SAW-1:0]                     clr_cnt_r;

  logic                               drv_we;
  logic [CW-1:0]                      drv_wa;
  logic signed [hslc_pkg::DATA_W-1:0] drv_wd;
  logic                               stg_we;
  logic [SAW-1:0]                     stg_wa;
  logic signed [hslc_pkg::DATA_W-1:0] stg_wd;

  // clearing pass sweeps every stage entry once, drive entries on stage zero
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r    <= 1'b1;
      clr_cnt_r <= '0;
    end else if (busy_r) begin
      clr_cnt_r <= clr_cnt_r + 1'b1;
      if (clr_cnt_r == SAW'(SDEPTH - 1)) begin
        busy_r <= 1'b0;
      end
    end
  end

  // write port select: sweep or datapath
  always_comb begin
    if (busy_r) begin
      drv_we = (clr_cnt_r[KW-1:0] == '0);
      drv_wa = clr_cnt_r[SAW-1:KW];
      drv_wd = hslc_pkg::GA0_Q16;
      stg_we = 1'b1;
      stg_wa = clr_cnt_r;
      stg_wd = '0;
    end else begin
      drv_we = mem_ctl.drv_we;
      drv_wa = drv_waddr;
      drv_wd = drv_wdata;
      stg_we = mem_ctl.stg_we;
      stg_wa = stg_waddr;
      stg_wd = stg_wdata;
    end
  end

  // drive memory
  always_ff @(posedge clk) begin
    if (drv_we) begin
      drv_mem[drv_wa] <= drv_wd;
    end
    drv_q_r <= drv_mem[drv_raddr];
  end

  // stage memory
  always_ff @(posedge clk) begin
    if (stg_we) begin
      stg_mem[stg_wa] <= stg_wd;
    end
    stg_q_r <= stg_mem[stg_raddr];
  end

  assign drv_rdata  = drv_q_r;
  assign stg_rdata  = stg_q_r;
  assign clear_busy = busy_r;

endmodule

### hw/rtl/hslc_core.sv
// ----------------------------------------------------------------------------
// hslc_core
// Sequencer and arithmetic: sigmoid drive, then the low-pass stages one at a
// time with read-modify-write of the channel state, and the result register.
// ----------------------------------------------------------------------------
module hslc_core #(
  parameter int CHANNELS            = hslc_pkg::CHANNELS_DEF,
  parameter int STAGES              = hslc_pkg::STAGES_DEF,
  parameter int SIGMOID_TABLE_DEPTH = hslc_pkg::SIG_DEPTH_DEF,
  localparam int CW                 = (CHANNELS > 1) ? $clog2(CHANNELS) : 1,
  localparam int KW                 = (STAGES > 1) ? $clog2(STAGES) : 1,
  localparam int SAW                = CW + KW,
  localparam int AW                 = $clog2(SIGMOID_TABLE_DEPTH)
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  // item in
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic [hslc_pkg::CH_W-1:0]            in_channel,
  input  logic signed [hslc_pkg::SAMPLE_W-1:0] in_sample,
  // settings
  input  logic [hslc_pkg::GAIN_W-1:0]          gain,
  input  logic [hslc_pkg::COEF_A_W-1:0]        coef_a,
  input  logic [hslc_pkg::COEF_B_W-1:0]        coef_b,
  // sigmoid rom
  output logic [AW-1:0]                        rom_addr,
  input  logic signed [hslc_pkg::ROM_W-1:0]    rom_data,
  // state memories
  output hslc_pkg::mem_ctl_t                   mem_ctl,
  output logic [CW-1:0]                        drv_raddr,
  output logic [CW-1:0]                        drv_waddr,
  output logic signed [hslc_pkg::DATA_W-1:0]   drv_wdata,
  input  logic signed [hslc_pkg::DATA_W-1:0]   drv_rdata,
  output logic [SAW-1:0]                       stg_raddr,
  output logic [SAW-1:0]                       stg_waddr,
  output logic signed [hslc_pkg::DATA_W-1:0]   stg_wdata,
  input  logic signed [hslc_pkg::DATA_W-1:0]   stg_rdata,
  input  logic                                 clear_busy,
  // result out
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic [hslc_pkg::CH_W-1:0]            out_channel,
  output logic signed [hslc_pkg::DATA_W-1:0]   out_response
);

  localparam int DPW = hslc_pkg::DRV_PROD_W;
  localparam int FPW = hslc_pkg::FB_PROD_W;
  localparam int FBW = hslc_pkg::FB_W;
  localparam int IW  = hslc_pkg::INNER_W;
  localparam int PW  = hslc_pkg::A_PROD_W;
  localparam int YW  = hslc_pkg::Y_W;

  localparam logic signed [18:0] IDX_OFS = 19'(SIGMOID_TABLE_DEPTH / 2 - 512);
  localparam logic signed [18:0] IDX_MAX = 19'(SIGMOID_TABLE_DEPTH - 1);
  localparam logic signed [YW-1:0] SAT_HI = YW'(64'sd2147483647);
  localparam logic signed [YW-1:0] SAT_LO = YW'(-64'sd2147483648);
  localparam logic [KW-1:0] K_LAST = KW'(STAGES - 1);

  hslc_pkg::seq_state_t state_r, state_nxt;

  logic [KW-1:0]                       k_r;
  logic [CW-1:0]                       ch_r;
  logic [hslc_pkg::CH_W-1:0]           chan_r;
  logic                                bad_r;
  logic signed [DPW-1:0]               drv_prod_r;
  logic signed [FPW-1:0]               fb_r;
  logic signed [hslc_pkg::DATA_W-1:0]  old_r;
  logic signed [hslc_pkg::DATA_W-1:0]  x_prev_r;
  logic signed [IW-1:0]                inner_r;
  logic signed [PW-1:0]                prod_r;
  logic                                out_valid_r;
  logic [hslc_pkg::CH_W-1:0]           out_channel_r;
  logic signed [hslc_pkg::DATA_W-1:0]  out_response_r;

  logic                                accept;
  logic                                out_load;
  logic                                bad_in;
  logic [CW-1:0]                       ch_in;
  logic [9:0]                          x_biased;
  logic signed [18:0]                  idx_s;
  logic signed [DPW-1:0]               drv_rnd;
  logic signed [hslc_pkg::DATA_W-1:0]  drive_val;
  logic signed [PW-1:0]                prod_rnd;
  logic signed [YW-1:0]                prod_sh;
  logic signed [hslc_pkg::DATA_W-1:0]  y_val;
  logic signed [FPW-1:0]               fb_sum;
  logic signed [FBW-1:0]               fb_val;
  logic signed [hslc_pkg::DATA_W-1:0]  xin;
  logic signed [IW-1:0]                inner_nxt;

  // input decode: channel range and clamped table index
  assign bad_in   = (32'(in_channel) >= 32'(CHANNELS));
  assign ch_in    = CW'(in_channel);
  assign x_biased = {~in_sample[15], in_sample[14:6]};
  assign idx_s    = $signed({9'b0, x_biased}) + IDX_OFS;

  always_comb begin
    if (idx_s < 19'sd0) begin
      rom_addr = '0;
    end else if (idx_s > IDX_MAX) begin
      rom_addr = AW'(IDX_MAX);
    end else begin
      rom_addr = AW'(idx_s);
    end
  end

  // drive: gain * entry rounded to Q16
  assign drv_rnd   = drv_prod_r + DPW'(128);
  assign drive_val = hslc_pkg::DATA_W'(drv_rnd >>> 8);

  // stage output: coef_a * inner rounded to Q16, saturated
  assign prod_rnd = prod_r + PW'(32768);
  assign prod_sh  = YW'(prod_rnd >>> 16);

  always_comb begin
    if (prod_sh > SAT_HI) begin
      y_val = hslc_pkg::DATA_W'(SAT_HI);
    end else if (prod_sh < SAT_LO) begin
      y_val = hslc_pkg::DATA_W'(SAT_LO);
    end else begin
      y_val = hslc_pkg::DATA_W'(prod_sh);
    end
  end

  // feedback rounding and stage sum
  assign fb_sum    = fb_r + FPW'(32768);
  assign fb_val    = FBW'(fb_sum >>> 16);
  assign xin       = (k_r == '0) ? drive_val : y_val;
  assign inner_nxt = IW'(xin) + IW'(x_prev_r) + IW'(fb_val);

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      hslc_pkg::ST_IDLE: begin
        if (accept) begin
          state_nxt = bad_in ? hslc_pkg::ST_FIN : hslc_pkg::ST_DRV;
        end
      end
      hslc_pkg::ST_DRV:  state_nxt = hslc_pkg::ST_SUM;
      hslc_pkg::ST_SUM:  state_nxt = hslc_pkg::ST_MULA;
      hslc_pkg::ST_MULA: state_nxt = (k_r == K_LAST) ? hslc_pkg::ST_FIN : hslc_pkg::ST_SUM;
      hslc_pkg::ST_FIN: begin
        if (out_load) begin
          state_nxt = hslc_pkg::ST_IDLE;
        end
      end
      default: state_nxt = hslc_pkg::ST_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    in_stall       = 1'b1;
    out_load       = 1'b0;
    mem_ctl.drv_we = 1'b0;
    mem_ctl.stg_we = 1'b0;
    stg_raddr      = {ch_r, KW'(k_r + 1'b1)};
    stg_waddr      = {ch_r, KW'(k_r - 1'b1)};
    unique case (state_r)
      hslc_pkg::ST_IDLE: begin
        in_stall  = clear_busy;
        stg_raddr = {ch_in, KW'(0)};
      end
      hslc_pkg::ST_SUM: begin
        mem_ctl.drv_we = (k_r == '0);
        mem_ctl.stg_we = (k_r != '0);
      end
      hslc_pkg::ST_FIN: begin
        out_load       = !out_valid_r || !out_stall;
        mem_ctl.stg_we = out_load && !bad_r;
        stg_waddr      = {ch_r, K_LAST};
      end
      default: ;
    endcase
  end

  assign accept    = in_valid && !in_stall;
  assign drv_raddr = ch_in;
  assign drv_waddr = ch_r;
  assign drv_wdata = drive_val;
  assign stg_wdata = y_val;

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= hslc_pkg::ST_IDLE;
      k_r         <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == hslc_pkg::ST_DRV) begin
        k_r <= '0;
      end else if (state_r == hslc_pkg::ST_MULA && k_r != K_LAST) begin
        k_r <= k_r + 1'b1;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (accept) begin
      ch_r   <= ch_in;
      chan_r <= in_channel;
      bad_r  <= bad_in;
    end
    case (state_r)
      hslc_pkg::ST_DRV: begin
        drv_prod_r <= $signed({1'b0, gain}) * rom_data;
        fb_r       <= $signed({1'b0, coef_b}) * stg_rdata;
        old_r      <= stg_rdata;
        x_prev_r   <= drv_rdata;
      end
      hslc_pkg::ST_SUM: begin
        inner_r  <= inner_nxt;
        x_prev_r <= old_r;
      end
      hslc_pkg::ST_MULA: begin
        prod_r <= $signed({1'b0, coef_a}) * inner_r;
        fb_r   <= $signed({1'b0, coef_b}) * stg_rdata;
        old_r  <= stg_rdata;
      end
      default: ;
    endcase
    if (out_load) begin
      out_channel_r  <= chan_r;
      out_response_r <= bad_r ? '0 : y_val;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_channel  = out_channel_r;
  assign out_response = out_response_r;

endmodule

### hw/rtl/haircell_sigmoid_lowpass_cascade.sv
// ----------------------------------------------------------------------------
// haircell_sigmoid_lowpass_cascade
// Inner hair cell drive: sigmoid lookup, gain, and a cascade of bilinear
// low-pass stages kept per channel.
// ----------------------------------------------------------------------------
// Usage
//   Input words (in_channel, in_sample) are taken on in_valid with in_stall
//   low; each word gives exactly one result word (out_channel, out_response)
//   on out_valid, held until out_stall is low.
//   An item walks through a sequencer: a step for the table and state
//   reads, a feedback/sum step then a coef_a multiply step per low-pass
//   stage, and a final step for the last write back and the result register.
//   A new word is taken only once the sequencer is idle again, after the
//   previous word has passed its final step; the stages run one after
//   another through read-modify-write of the shared stage state memory.
//   A word whose channel is out of range skips to the final step, returns 0
//   and leaves the state alone.
//   After reset a clearing pass over every stage entry loads the state;
//   in_stall stays high meanwhile, and the register port works throughout.
//   A stalled result sits in the output register; the next item is taken
//   and runs, and waits only at its final step for that register to free.
//   Registers gain, coef_a, coef_b lie at 0x0, 0x4, 0x8; write them idle.
// ----------------------------------------------------------------------------
module haircell_sigmoid_lowpass_cascade #(
  parameter int CHANNELS            = hslc_pkg::CHANNELS_DEF,
  parameter int STAGES              = hslc_pkg::STAGES_DEF,
  parameter int SIGMOID_TABLE_DEPTH = hslc_pkg::SIG_DEPTH_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  // input words
  input  logic                                   in_valid,
  output logic                                   in_stall,
  input  logic [hslc_pkg::CH_W-1:0]              in_channel,
  input  logic signed [hslc_pkg::SAMPLE_W-1:0]   in_sample,
  // result words
  output logic                                   out_valid,
  input  logic                                   out_stall,
  output logic [hslc_pkg::CH_W-1:0]              out_channel,
  output logic signed [hslc_pkg::DATA_W-1:0]     out_response,
  // register port
  input  logic                                   cfg_psel,
  input  logic                                   cfg_penable,
  input  logic                                   cfg_pwrite,
  input  logic [hslc_pkg::CFG_ADDR_W-1:0]        cfg_paddr,
  input  logic [hslc_pkg::CFG_DATA_W-1:0]        cfg_pwdata,
  output logic [hslc_pkg::CFG_DATA_W-1:0]        cfg_prdata,
  output logic                                   cfg_pready
);

  localparam int CW  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int KW  = (STAGES > 1) ? $clog2(STAGES) : 1;
  localparam int SAW = CW + KW;
  localparam int AW  = $clog2(SIGMOID_TABLE_DEPTH);

  logic [hslc_pkg::GAIN_W-1:0]   gain_r;
  logic [hslc_pkg::COEF_A_W-1:0] coef_a_r;
  logic [hslc_pkg::COEF_B_W-1:0] coef_b_r;
  logic                          cfg_wr;

  logic [AW-1:0]                       rom_addr;
  logic signed [hslc_pkg::ROM_W-1:0]   rom_data;
  hslc_pkg::mem_ctl_t                  mem_ctl;
  logic [CW-1:0]                       drv_raddr;
  logic [CW-1:0]                       drv_waddr;
  logic signed [hslc_pkg::DATA_W-1:0]  drv_wdata;
  logic signed [hslc_pkg::DATA_W-1:0]  drv_rdata;
  logic [SAW-1:0]                      stg_raddr;
  logic [SAW-1:0]                      stg_waddr;
  logic signed [hslc_pkg::DATA_W-1:0]  stg_wdata;
  logic signed [hslc_pkg::DATA_W-1:0]  stg_rdata;
  logic                                clear_busy;

  // register writes
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gain_r   <= hslc_pkg::GAIN_RST;
      coef_a_r <= hslc_pkg::COEF_A_RST;
      coef_b_r <= hslc_pkg::COEF_B_RST;
    end else if (cfg_wr) begin
      unique case (cfg_paddr[3:2])
        hslc_pkg::REG_GAIN:   gain_r   <= cfg_pwdata[hslc_pkg::GAIN_W-1:0];
        hslc_pkg::REG_COEF_A: coef_a_r <= cfg_pwdata[hslc_pkg::COEF_A_W-1:0];
        hslc_pkg::REG_COEF_B: coef_b_r <= cfg_pwdata[hslc_pkg::COEF_B_W-1:0];
        default: ;
      endcase
    end
  end

  // register reads
  always_comb begin
    unique case (cfg_paddr[3:2])
      hslc_pkg::REG_GAIN:   cfg_prdata = hslc_pkg::CFG_DATA_W'(gain_r);
      hslc_pkg::REG_COEF_A: cfg_prdata = hslc_pkg::CFG_DATA_W'(coef_a_r);
      hslc_pkg::REG_COEF_B: cfg_prdata = hslc_pkg::CFG_DATA_W'(coef_b_r);
      default:              cfg_prdata = '0;
    endcase
  end

  hslc_sig_rom #(
    .SIGMOID_TABLE_DEPTH (SIGMOID_TABLE_DEPTH)
  ) u_sig_rom (
    .clk      (clk),
    .rom_addr (rom_addr),
    .rom_data (rom_data)
  );

  hslc_state_mem #(
    .CHANNELS (CHANNELS),
    .STAGES   (STAGES)
  ) u_state_mem (
    .clk        (clk),
    .rst_n      (rst_n),
    .mem_ctl    (mem_ctl),
    .drv_raddr  (drv_raddr),
    .drv_waddr  (drv_waddr),
    .drv_wdata  (drv_wdata),
    .drv_rdata  (drv_rdata),
    .stg_raddr  (stg_raddr),
    .stg_waddr  (stg_waddr),
    .stg_wdata  (stg_wdata),
    .stg_rdata  (stg_rdata),
    .clear_busy (clear_busy)
  );

  hslc_core #(
    .CHANNELS            (CHANNELS),
    .STAGES              (STAGES),
    .SIGMOID_TABLE_DEPTH (SIGMOID_TABLE_DEPTH)
  ) u_core (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_channel   (in_channel),
    .in_sample    (in_sample),
    .gain         (gain_r),
    .coef_a       (coef_a_r),
    .coef_b       (coef_b_r),
    .rom_addr     (rom_addr),
    .rom_data     (rom_data),
    .mem_ctl      (mem_ctl),
    .drv_raddr    (drv_raddr),
    .drv_waddr    (drv_waddr),
    .drv_wdata    (drv_wdata),
    .drv_rdata    (drv_rdata),
    .stg_raddr    (stg_raddr),
    .stg_waddr    (stg_waddr),
    .stg_wdata    (stg_wdata),
    .stg_rdata    (stg_rdata),
    .clear_busy   (clear_busy),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_channel  (out_channel),
    .out_response (out_response)
  );

endmodule
